// ===== hdl/rtc_snapshot_to_epoch_unit_assert.svh =====
// assertion macros for the rtc snapshot to epoch unit
// expects clk and rst_n in the scope where a macro is used
`ifndef RTC_SNAPSHOT_TO_EPOCH_UNIT_ASSERT_SVH
`define RTC_SNAPSHOT_TO_EPOCH_UNIT_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rse_pkg.sv =====
// shared types, constants and helper functions for the rtc snapshot to epoch unit
// no dependencies
package rse_pkg;

  localparam int unsigned BIN_MODE_IDX = 2;
  localparam int unsigned H24_MODE_IDX = 1;
  localparam int unsigned PM_IDX       = 7;

  localparam logic [15:0] EPOCH_YEAR         = 16'd1970;
  localparam logic [31:0] LEAPS_BEFORE_EPOCH = 32'd477;  // leap years in 1..1969
  localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
  localparam logic [25:0] RECIP_25           = 26'd5243; // ceil(2^17 / 25)
  localparam int unsigned RECIP_25_SHIFT     = 17;
  localparam logic [3:0]  MONTHS_PER_YEAR    = 4'd12;

  typedef struct packed {
    logic [7:0] century;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] weekday;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } rse_raw_t;

  typedef struct packed {
    logic [15:0] full_year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  weekday;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } rse_time_t;

  typedef struct packed {
    rse_time_t   tm;
    logic [8:0]  y_d100;
    logic [6:0]  y_d400;
    logic [8:0]  p_d100;
    logic [6:0]  p_d400;
    logic [23:0] span365;
    logic [19:0] tsec;
    logic        after_epoch;
  } rse_prep_t;

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    return {4'd0, b[3:0]} + 8'(b[7:4]) * 8'd10;
  endfunction

  // input never exceeds 139, so five subtractions are enough
  function automatic logic [7:0] mod24(input logic [7:0] x);
    logic [7:0] v;
    v = x;
    for (int i = 0; i < 5; i++) begin
      if (v >= 8'd24) v = v - 8'd24;
    end
    return v;
  endfunction

  // exact x / 25 for x below 8192
  function automatic logic [8:0] div25(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * RECIP_25;
    return 9'(p >> RECIP_25_SHIFT);
  endfunction

  // days before the first of month m+1 in a common year
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/rse_snap_filter.sv =====
// holds the last accepted snapshot that was not busy and flags a repeat of it
// depends on rse_pkg
module rse_snap_filter import rse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic     busy,
  input  rse_raw_t snap,
  output logic     repeat_hit
);

  rse_raw_t prev_r;
  logic     valid_r;

  assign repeat_hit = !busy && valid_r && (prev_r == snap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      valid_r <= 1'b0;
    end else if (accept && !busy) begin
      prev_r  <= snap;
      valid_r <= 1'b1;
    end
  end

endmodule

// ===== hdl/rse_field_decode.sv =====
// bcd or binary field decode, 12/24 hour fix-up and full year of one snapshot
// depends on rse_pkg
module rse_field_decode import rse_pkg::*; (
  input  rse_raw_t  raw,
  input  logic [7:0] fmt,
  output rse_time_t tm
);

  logic [7:0] sec, min, hr, wd, dy, mo, yr, cen;

  always_comb begin
    if (fmt[BIN_MODE_IDX]) begin
      sec = raw.second;
      min = raw.minute;
      hr  = raw.hour;
      wd  = raw.weekday;
      dy  = raw.day;
      mo  = raw.month;
      yr  = raw.year;
      cen = raw.century;
    end else begin
      sec = bcd_decode(raw.second);
      min = bcd_decode(raw.minute);
      // pm flag survives the decode
      hr  = {raw.hour[PM_IDX], 7'(bcd_decode({1'b0, raw.hour[6:0]}))};
      wd  = bcd_decode(raw.weekday);
      dy  = bcd_decode(raw.day);
      mo  = bcd_decode(raw.month);
      yr  = bcd_decode(raw.year);
      cen = bcd_decode(raw.century);
    end
    if (!fmt[H24_MODE_IDX] && hr[PM_IDX]) begin
      hr = mod24({1'b0, hr[6:0]} + 8'd12);
    end
  end

  assign tm.second    = sec;
  assign tm.minute    = min;
  assign tm.hour      = hr;
  assign tm.weekday   = wd;
  assign tm.day       = dy;
  assign tm.month     = mo;
  assign tm.full_year = 16'(yr) + 16'(cen) * 16'd100;

endmodule

// ===== hdl/rse_year_prep.sv =====
// century divisions, whole-year span and time-of-day seconds
// depends on rse_pkg
module rse_year_prep import rse_pkg::*; (
  input  rse_time_t tm,
  output rse_prep_t prep
);

  logic [15:0] y, p, diff;

  // full year stays below 2^15, so bits 14:2 carry y/4
  assign y    = tm.full_year;
  assign p    = y - 16'd1;
  assign diff = y - EPOCH_YEAR;

  assign prep.tm          = tm;
  assign prep.y_d100      = div25(y[14:2]);
  assign prep.y_d400      = 7'(div25({2'b00, y[14:4]}));
  assign prep.p_d100      = div25(p[14:2]);
  assign prep.p_d400      = 7'(div25({2'b00, p[14:4]}));
  assign prep.span365     = 24'(24'(diff) * 24'd365);
  assign prep.tsec        = 20'(tm.hour) * 20'd3600 + 20'(tm.minute) * 20'd60
                          + 20'(tm.second);
  assign prep.after_epoch = (y > EPOCH_YEAR);

endmodule

// ===== hdl/rse_day_count.sv =====
// days since 1970-01-01 from the prepared year terms, month and day
// depends on rse_pkg
module rse_day_count import rse_pkg::*; (
  input  rse_prep_t   prep,
  output logic [31:0] days
);

  logic [15:0] y, p, leaps_y, leaps_p;
  logic        leap;
  logic [3:0]  mon_idx;
  logic [31:0] year_days;

  assign y = prep.tm.full_year;
  assign p = y - 16'd1;

  assign leaps_y = {2'b00, y[15:2]} - 16'(prep.y_d100) + 16'(prep.y_d400);
  assign leaps_p = {2'b00, p[15:2]} - 16'(prep.p_d100) + 16'(prep.p_d400);

  // year zero is a leap year; otherwise the leap count steps at y
  assign leap = (y == 16'd0) || (leaps_y != leaps_p);

  always_comb begin
    if (prep.tm.month == 8'd0) begin
      mon_idx = 4'd0;
    end else if ((prep.tm.month - 8'd1) > 8'(MONTHS_PER_YEAR)) begin
      mon_idx = MONTHS_PER_YEAR;
    end else begin
      mon_idx = 4'(prep.tm.month - 8'd1);
    end
  end

  assign year_days = prep.after_epoch
                   ? 32'(prep.span365) + 32'(leaps_p) - LEAPS_BEFORE_EPOCH
                   : 32'd0;

  assign days = year_days + 32'(month_cum(mon_idx))
              + 32'(leap && (mon_idx >= 4'd2))
              + 32'(prep.tm.day) - 32'd1;

endmodule

// ===== hdl/rtc_snapshot_to_epoch_unit.sv =====
// Converts raw CMOS RTC register snapshots into decoded time fields and seconds
// since 1970. A snapshot flagged busy is dropped; any other snapshot is stored,
// and only one that repeats the stored snapshot byte for byte yields a result.
// The unit is a six-register pipeline (input, decode, year terms, day count,
// day-to-second multiply, output) and takes one transfer per cycle while no
// stall reaches the input; bubbles let new snapshots in while a result waits
// at the output.
// depends on rse_pkg, the four rse_ submodules and the assertion macro header
`include "rtc_snapshot_to_epoch_unit_assert.svh"

module rtc_snapshot_to_epoch_unit import rse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // raw_second, raw_minute, raw_hour, raw_weekday, raw_day, raw_month,
  // raw_year, raw_century, format_byte (8 bits each)
  input  logic [71:0] in_tdata,
  // update_busy
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // second, minute, hour, weekday, day, month (8 each), full_year (16),
  // epoch_seconds (32)
  output logic [95:0] out_tdata
);

  logic        in_acc, repeat_hit;
  logic        rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

  rse_raw_t    s1_raw_r;
  logic [7:0]  s1_fmt_r;
  logic        s1_v_r;
  rse_time_t   s2_time_r, dec_time;
  logic        s2_v_r;
  rse_prep_t   s3_prep_r, prep;
  logic        s3_v_r;
  logic [31:0] s4_days_r, days;
  logic [19:0] s4_tsec_r;
  rse_time_t   s4_time_r;
  logic        s4_v_r;
  logic [31:0] s5_dsec_r;
  logic [19:0] s5_tsec_r;
  rse_time_t   s5_time_r;
  logic        s5_v_r;
  logic [95:0] out_data_r;
  logic        out_v_r;

  // a stage moves when it is empty or the next one moves
  assign rdy_o = !out_v_r || out_tready;
  assign rdy5  = !s5_v_r || rdy_o;
  assign rdy4  = !s4_v_r || rdy5;
  assign rdy3  = !s3_v_r || rdy4;
  assign rdy2  = !s2_v_r || rdy3;
  assign rdy1  = !s1_v_r || rdy2;

  assign in_tready  = rdy1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  rse_snap_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .busy       (in_tuser),
    .snap       (rse_raw_t'(in_tdata[63:0])),
    .repeat_hit (repeat_hit)
  );

  rse_field_decode u_decode (
    .raw (s1_raw_r),
    .fmt (s1_fmt_r),
    .tm  (dec_time)
  );

  rse_year_prep u_prep (
    .tm   (s2_time_r),
    .prep (prep)
  );

  rse_day_count u_days (
    .prep (s3_prep_r),
    .days (days)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)  s1_v_r  <= in_acc && repeat_hit;
      if (rdy2)  s2_v_r  <= s1_v_r;
      if (rdy3)  s3_v_r  <= s2_v_r;
      if (rdy4)  s4_v_r  <= s3_v_r;
      if (rdy5)  s5_v_r  <= s4_v_r;
      if (rdy_o) out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_raw_r <= rse_raw_t'(in_tdata[63:0]);
      s1_fmt_r <= in_tdata[71:64];
    end
    if (rdy2) s2_time_r <= dec_time;
    if (rdy3) s3_prep_r <= prep;
    if (rdy4) begin
      s4_days_r <= days;
      s4_tsec_r <= s3_prep_r.tsec;
      s4_time_r <= s3_prep_r.tm;
    end
    if (rdy5) begin
      s5_dsec_r <= 32'(s4_days_r * SECS_PER_DAY);
      s5_tsec_r <= s4_tsec_r;
      s5_time_r <= s4_time_r;
    end
    if (rdy_o) begin
      out_data_r <= {s5_dsec_r + 32'(s5_tsec_r), s5_time_r};
    end
  end

  `RSE_ASSERT_SAME(a_s1_from_repeat, $rose(s1_v_r), $past(in_acc && !in_tuser), "pipeline entry without a repeated snapshot transfer")
  `RSE_ASSERT_NEXT(a_s3_holds, s3_v_r && !rdy4, s3_v_r, "stalled year stage lost its item")
  `RSE_ASSERT_SAME(a_out_from_s5, $rose(out_v_r), $past(s5_v_r), "result appeared without a multiply stage item")
  `RSE_ASSERT_SAME(a_busy_no_entry, $past(in_acc && in_tuser && rdy1), !s1_v_r, "busy snapshot entered the pipeline")

endmodule

// ===== tb/tb_rtc_snapshot_to_epoch_unit.sv =====
// self-checking testbench for rtc_snapshot_to_epoch_unit: directed and random rtc snapshots
// go in, and decoded time and epoch seconds are checked against a cycle-free predictor
// depends on rse_pkg and the rtc_snapshot_to_epoch_unit rtl
`timescale 1ns / 1ps

module tb_rtc_snapshot_to_epoch_unit;
  import rse_pkg::*;

  localparam int unsigned LATENCY     = 6;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_ITEMS = 700;

  localparam logic [7:0] FMT_BIN  = 8'h04;
  localparam logic [7:0] FMT_24H  = 8'h02;
  localparam logic [7:0] FMT_BCD12 = 8'h00;
  localparam logic [7:0] PM_FLAG  = 8'h80;
  localparam logic       UPDATE_BUSY = 1'b1;
  localparam logic       UPDATE_IDLE = 1'b0;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [31:0] epoch_seconds;
    rse_time_t   tm;
  } decoded_time_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  decoded_time_t epoch_results_due[$];
  rse_raw_t      last_snapshot = '0;
  bit            last_snapshot_held = 1'b0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_phase = 0;
  int unsigned   stall_mode = 0;

  rtc_snapshot_to_epoch_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rtc_snapshot_to_epoch_unit regression: fail");
      $finish;
    end
  end

  function automatic int unsigned bcd_value(int unsigned b);
    return (b & 32'h0F) + (b >> 4) * 10;
  endfunction

  function automatic int unsigned leap_count(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic bit is_gregorian_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // decoded fields and seconds since 1970 for one repeated snapshot
  function automatic decoded_time_t decode_snapshot(rse_raw_t s, logic [7:0] fmt);
    int unsigned sec, mins, hr, wd, dy, mo, yr, cen, year, days, months, secs;
    decoded_time_t d;
    sec = s.second;
    mins = s.minute;
    hr = s.hour;
    wd = s.weekday;
    dy = s.day;
    mo = s.month;
    yr = s.year;
    cen = s.century;
    if (!fmt[BIN_MODE_IDX]) begin
      sec = bcd_value(sec);
      mins = bcd_value(mins);
      hr = (hr & PM_FLAG) | bcd_value(hr & ~32'(PM_FLAG) & 32'hFF);
      wd = bcd_value(wd);
      dy = bcd_value(dy);
      mo = bcd_value(mo);
      yr = bcd_value(yr);
      cen = bcd_value(cen);
    end
    // pm only applies in 12-hour mode; 24-hour mode keeps bit 7 in the hour
    if (!fmt[H24_MODE_IDX] && (hr & PM_FLAG) != 0)
      hr = ((hr & ~32'(PM_FLAG) & 32'hFF) + 12) % 24;
    year = (yr + cen * 100) & 32'hFFFF;
    days = 0;
    if (year > EPOCH_YEAR)
      days = 365 * (year - EPOCH_YEAR) + leap_count(year - 1) - leap_count(EPOCH_YEAR - 1);
    months = (mo > 0) ? mo - 1 : 0;
    if (months > 12) months = 12;
    for (int unsigned i = 0; i < months; i++) begin
      days += MONTH_LEN[i];
      if (i == 1 && is_gregorian_leap(year)) days += 1;
    end
    days += dy - 1;
    secs = days * 86400 + hr * 3600 + mins * 60 + sec;
    d.tm.second = sec[7:0];
    d.tm.minute = mins[7:0];
    d.tm.hour = hr[7:0];
    d.tm.weekday = wd[7:0];
    d.tm.day = dy[7:0];
    d.tm.month = mo[7:0];
    d.tm.full_year = year[15:0];
    d.epoch_seconds = secs;
    return d;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result check first, then record what an accepted snapshot will produce
  always @(posedge clk) begin
    decoded_time_t want, got;
    rse_raw_t snap;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (epoch_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = epoch_results_due.pop_front();
          check_field("second", want.tm.second, got.tm.second);
          check_field("minute", want.tm.minute, got.tm.minute);
          check_field("hour", want.tm.hour, got.tm.hour);
          check_field("weekday", want.tm.weekday, got.tm.weekday);
          check_field("day", want.tm.day, got.tm.day);
          check_field("month", want.tm.month, got.tm.month);
          check_field("full_year", want.tm.full_year, got.tm.full_year);
          check_field("epoch_seconds", want.epoch_seconds, got.epoch_seconds);
        end
      end
      if (in_tvalid && in_tready && in_tuser != UPDATE_BUSY) begin
        snap = in_tdata[63:0];
        if (last_snapshot_held && last_snapshot == snap)
          epoch_results_due.push_back(decode_snapshot(snap, in_tdata[71:64]));
        last_snapshot = snap;
        last_snapshot_held = 1'b1;
      end
    end
  end

  // receiver: a new stall pattern is drawn each time the low six bits of stall_phase are zero
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (stall_phase[1:0] == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_snapshot(input rse_raw_t snap, input logic [7:0] fmt, input logic busy);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {fmt, snap};
    in_tuser <= busy;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off until every expected result is out and the pipeline is empty
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (epoch_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [7:0] rtc_byte(int unsigned v, bit binary);
    return binary ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic rse_raw_t plausible_snapshot(bit binary, bit h24);
    rse_raw_t s;
    int unsigned hr;
    logic [7:0] pm;
    hr = h24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
    pm = (!h24 && $urandom_range(0, 1) == 1) ? PM_FLAG : 8'h00;
    s.second = rtc_byte($urandom_range(0, 59), binary);
    s.minute = rtc_byte($urandom_range(0, 59), binary);
    s.hour = rtc_byte(hr, binary) | pm;
    s.weekday = rtc_byte($urandom_range(1, 7), binary);
    s.day = rtc_byte($urandom_range(1, 31), binary);
    s.month = rtc_byte($urandom_range(1, 12), binary);
    s.year = rtc_byte($urandom_range(0, 99), binary);
    s.century = rtc_byte($urandom_range(19, 21), binary);
    return s;
  endfunction

  // all-zero first snapshot must not match the zero reset state
  task automatic test_first_snapshot();
    send_snapshot('0, FMT_BCD12, UPDATE_IDLE);
    send_snapshot('0, FMT_BCD12, UPDATE_IDLE);
  endtask

  task automatic test_busy_drop();
    rse_raw_t leap_day;
    leap_day = {8'h20, 8'h24, 8'h02, 8'h29, 8'h04, 8'h23, 8'h59, 8'h59};
    send_snapshot(leap_day, FMT_24H, UPDATE_IDLE);
    send_snapshot(~leap_day, FMT_24H, UPDATE_BUSY);
    send_snapshot(leap_day, FMT_24H, UPDATE_IDLE);
    // a busy snapshot is not stored, so the next one does not repeat it
    send_snapshot({8'h20, 8'h23, 8'h12, 8'h31, 8'h07, 8'h00, 8'h00, 8'h01},
                  FMT_24H, UPDATE_BUSY);
    send_snapshot({8'h20, 8'h23, 8'h12, 8'h31, 8'h07, 8'h00, 8'h00, 8'h01},
                  FMT_24H, UPDATE_IDLE);
  endtask

  // format byte is not compared, the repeat decides the decoding
  task automatic test_binary_mode();
    rse_raw_t bin_day;
    bin_day = {8'd20, 8'd24, 8'd2, 8'd29, 8'd4, 8'd23, 8'd59, 8'd59};
    send_snapshot(bin_day, FMT_BCD12, UPDATE_IDLE);
    send_snapshot(bin_day, FMT_BIN | FMT_24H, UPDATE_IDLE);
  endtask

  task automatic test_pm_hour();
    rse_raw_t noon_pm, late_pm, h24_flag;
    noon_pm = {8'h20, 8'h01, 8'h06, 8'h15, 8'h03, PM_FLAG | 8'h12, 8'h30, 8'h45};
    late_pm = {8'h20, 8'h01, 8'h06, 8'h15, 8'h03, PM_FLAG | 8'h11, 8'h30, 8'h45};
    h24_flag = {8'h20, 8'h01, 8'h06, 8'h15, 8'h03, PM_FLAG | 8'h05, 8'h30, 8'h45};
    send_snapshot(noon_pm, FMT_BCD12, UPDATE_IDLE);
    send_snapshot(noon_pm, FMT_BCD12, UPDATE_IDLE);
    send_snapshot(late_pm, FMT_BCD12, UPDATE_IDLE);
    send_snapshot(late_pm, FMT_BCD12, UPDATE_IDLE);
    send_snapshot(h24_flag, FMT_24H, UPDATE_IDLE);
    send_snapshot(h24_flag, FMT_24H, UPDATE_IDLE);
  endtask

  task automatic test_field_extremes();
    send_snapshot('1, 8'h00, UPDATE_IDLE);
    send_snapshot('1, 8'h00, UPDATE_IDLE);
    send_snapshot('1, 8'hFF, UPDATE_IDLE);
    // month beyond twelve, year before the epoch, day zero
    send_snapshot({8'h19, 8'h69, 8'h13, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00},
                  FMT_24H, UPDATE_IDLE);
    send_snapshot({8'h19, 8'h69, 8'h13, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00},
                  FMT_24H, UPDATE_IDLE);
    // month zero in a century leap year
    send_snapshot({8'h20, 8'h00, 8'h00, 8'h01, 8'h06, 8'h08, 8'h00, 8'h00},
                  FMT_24H, UPDATE_IDLE);
    send_snapshot({8'h20, 8'h00, 8'h00, 8'h01, 8'h06, 8'h08, 8'h00, 8'h00},
                  FMT_24H, UPDATE_IDLE);
  endtask

  task automatic test_random_snapshots(input int unsigned count);
    int unsigned sent, next_pause, kind;
    rse_raw_t snap;
    logic [7:0] fmt, fmt2;
    bit binary, h24;
    sent = 0;
    next_pause = 150;
    while (sent < count) begin
      binary = 1'($urandom_range(0, 1));
      h24 = 1'($urandom_range(0, 1));
      fmt = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        snap = {$urandom, $urandom};
      end else begin
        snap = plausible_snapshot(binary, h24);
        fmt[BIN_MODE_IDX] = binary;
        fmt[H24_MODE_IDX] = h24;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          send_snapshot(snap, fmt, UPDATE_IDLE);
          if ($urandom_range(0, 2) == 0)
            send_snapshot({$urandom, $urandom}, 8'($urandom_range(0, 255)), UPDATE_BUSY);
          fmt2 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : fmt;
          send_snapshot(snap, fmt2, UPDATE_IDLE);
          sent += 2;
        end
        6: begin
          send_snapshot(snap, fmt, UPDATE_IDLE);
          sent += 1;
        end
        7: begin
          // one flipped bit must break the match
          send_snapshot(snap, fmt, UPDATE_IDLE);
          snap = snap ^ (64'(1) << $urandom_range(0, 63));
          send_snapshot(snap, fmt, UPDATE_IDLE);
          sent += 2;
        end
        8: begin
          send_snapshot(snap, fmt, UPDATE_BUSY);
        end
        default: begin
          repeat (3) send_snapshot(snap, fmt, UPDATE_IDLE);
          sent += 3;
        end
      endcase
      if (sent >= next_pause) begin
        wait_for_drain();
        next_pause += 150;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_first_snapshot();
    test_busy_drop();
    test_binary_mode();
    test_pm_hour();
    test_field_extremes();
    wait_for_drain();
    test_random_snapshots(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    while (epoch_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("rtc_snapshot_to_epoch_unit regression: pass");
    end else begin
      $display("rtc_snapshot_to_epoch_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rse_pkg.sv
hdl/rse_snap_filter.sv
hdl/rse_field_decode.sv
hdl/rse_year_prep.sv
hdl/rse_day_count.sv
hdl/rtc_snapshot_to_epoch_unit.sv
tb/tb_rtc_snapshot_to_epoch_unit.sv
